// ----- rtl/cpe_pkg.sv -----
// Package for the clamped polynomial evaluator: Q16.16 and sum types, pipeline
// sizing, configuration register codes and the rounding and saturation helpers.
// No dependencies.
package cpe_pkg;

	localparam int NUM_TERMS   = 10;
	localparam int COEF_FIELDS = 10;
	localparam int Q_W         = 32;
	localparam int PROD_W      = 2 * Q_W;
	localparam int FRAC_W      = 16;
	localparam int TERM_W      = PROD_W - FRAC_W;
	localparam int OUT_W       = 48;
	localparam int ACC_W       = TERM_W + $clog2(NUM_TERMS) + 1;
	localparam int CFG_IDX_W   = 1;
	// input register, two stages per term, output register
	localparam int LATENCY     = 2 * NUM_TERMS + 2;

	typedef logic signed [Q_W-1:0]    q16_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [OUT_W-1:0]  out_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOWER = 1'b0,
		REG_UPPER = 1'b1
	} cfg_reg_t;

	localparam q16_t  Q_ONE    = q16_t'(1 << FRAC_W);
	localparam prod_t HALF_LSB = prod_t'(1 << (FRAC_W - 1));
	localparam q16_t  Q_MAX    = {1'b0, {(Q_W-1){1'b1}}};
	localparam q16_t  Q_MIN    = {1'b1, {(Q_W-1){1'b0}}};
	localparam out_t  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
	localparam out_t  OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};

	// Round to nearest, ties toward +infinity, dropping the fraction bits.
	function automatic term_t round_q16(input prod_t v);
		prod_t t;
		t = v + HALF_LSB;
		return t[PROD_W-1:FRAC_W];
	endfunction

	function automatic q16_t sat_q16(input term_t v);
		q16_t r;
		if (v > term_t'(Q_MAX))
			r = Q_MAX;
		else if (v < term_t'(Q_MIN))
			r = Q_MIN;
		else
			r = v[Q_W-1:0];
		return r;
	endfunction

	function automatic out_t sat_out(input acc_t v);
		out_t r;
		if (v > acc_t'(OUT_MAX))
			r = OUT_MAX;
		else if (v < acc_t'(OUT_MIN))
			r = OUT_MIN;
		else
			r = v[OUT_W-1:0];
		return r;
	endfunction

endpackage

// ----- rtl/clamped_polynomial_eval_unit.sv -----
// Clamped polynomial evaluator: y = sum of coef_i * x^i over a pipeline of
// multiply and round stages. Depends on cpe_pkg.
//
// Usage: pulse start with sample and coef_0..coef_9 present; busy stays low,
// so an item may be issued every clock cycle. Each item yields one
// poly_value, shown for one cycle with done high; results leave in issue order.
// Sustained rate is one item per cycle; latency is set by one register on
// the input, a multiply stage and a round/accumulate stage for each term,
// and the output register.
// The limit registers sit on a separate write port (cfg_valid, cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high. Write them only while no
// item is in flight. Both limits zero leaves the sample unclamped.
// Reset clears the limits and every valid bit in flight; items inside the
// pipeline at reset are dropped. The receiver cannot stall, so the pipeline
// advances on every clock.
module clamped_polynomial_eval_unit
	import cpe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  q16_t                 sample,
	input  q16_t                 coef_0,
	input  q16_t                 coef_1,
	input  q16_t                 coef_2,
	input  q16_t                 coef_3,
	input  q16_t                 coef_4,
	input  q16_t                 coef_5,
	input  q16_t                 coef_6,
	input  q16_t                 coef_7,
	input  q16_t                 coef_8,
	input  q16_t                 coef_9,
	output logic                 done,
	output out_t                 poly_value,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  q16_t                 cfg_data
);

	q16_t lower_q, upper_q;
	q16_t coef_in [COEF_FIELDS];
	q16_t x_clamped;

	logic vld_s0;
	q16_t x_s0;
	q16_t coef_s0 [COEF_FIELDS];

	logic  vld_s1   [NUM_TERMS];
	prod_t cprod_s1 [NUM_TERMS];
	prod_t xprod_s1 [NUM_TERMS];
	q16_t  x_s1     [NUM_TERMS];
	acc_t  acc_s1   [NUM_TERMS];
	q16_t  coef_s1  [NUM_TERMS][COEF_FIELDS];

	logic vld_s2  [NUM_TERMS];
	q16_t pw_s2   [NUM_TERMS];
	q16_t x_s2    [NUM_TERMS];
	acc_t acc_s2  [NUM_TERMS];
	q16_t coef_s2 [NUM_TERMS][COEF_FIELDS];

	logic done_q;
	out_t poly_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	assign coef_in[0] = coef_0;
	assign coef_in[1] = coef_1;
	assign coef_in[2] = coef_2;
	assign coef_in[3] = coef_3;
	assign coef_in[4] = coef_4;
	assign coef_in[5] = coef_5;
	assign coef_in[6] = coef_6;
	assign coef_in[7] = coef_7;
	assign coef_in[8] = coef_8;
	assign coef_in[9] = coef_9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOWER: lower_q <= cfg_data;
				REG_UPPER: upper_q <= cfg_data;
			endcase
		end
	end

	// Raise to the floor first, then lower to the ceiling
	always_comb begin
		x_clamped = sample;
		if (lower_q != '0 || upper_q != '0) begin
			if (x_clamped < lower_q)
				x_clamped = lower_q;
			if (x_clamped > upper_q)
				x_clamped = upper_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s0 <= 1'b0;
		else
			vld_s0 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		x_s0    <= x_clamped;
		coef_s0 <= coef_in;
	end

	for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
		logic vld_in;
		q16_t x_in;
		q16_t pw_in;
		acc_t acc_in;
		q16_t cf_in [COEF_FIELDS];
		q16_t c_k;

		if (k == 0) begin : g_first
			assign vld_in = vld_s0;
			assign x_in   = x_s0;
			assign pw_in  = Q_ONE;
			assign acc_in = '0;
			assign cf_in  = coef_s0;
		end else begin : g_next
			assign vld_in = vld_s2[k-1];
			assign x_in   = x_s2[k-1];
			assign pw_in  = pw_s2[k-1];
			assign acc_in = acc_s2[k-1];
			assign cf_in  = coef_s2[k-1];
		end

		// Terms past the coefficient fields add nothing
		if (k < COEF_FIELDS) begin : g_coef
			assign c_k = cf_in[k];
		end else begin : g_zero
			assign c_k = '0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[k] <= 1'b0;
				vld_s2[k] <= 1'b0;
			end else begin
				vld_s1[k] <= vld_in;
				vld_s2[k] <= vld_s1[k];
			end
		end

		always_ff @(posedge clk) begin
			cprod_s1[k] <= prod_t'(c_k) * prod_t'(pw_in);
			xprod_s1[k] <= prod_t'(pw_in) * prod_t'(x_in);
			x_s1[k]     <= x_in;
			acc_s1[k]   <= acc_in;
			coef_s1[k]  <= cf_in;
		end

		always_ff @(posedge clk) begin
			acc_s2[k]  <= acc_s1[k] + acc_t'(round_q16(cprod_s1[k]));
			pw_s2[k]   <= sat_q16(round_q16(xprod_s1[k]));
			x_s2[k]    <= x_s1[k];
			coef_s2[k] <= coef_s1[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= vld_s2[NUM_TERMS-1];
	end

	always_ff @(posedge clk) begin
		poly_q <= sat_out(acc_s2[NUM_TERMS-1]);
	end

	assign done       = done_q;
	assign poly_value = poly_q;

`ifndef SYNTHESIS
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("item taken without a result after the pipeline latency");

	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching item");

	a_const_term: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2[0] |-> acc_s2[0] == acc_t'(coef_s2[0][0]))
		else $error("constant term not carried exactly into the sum");

	a_first_power: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2[0] |-> pw_s2[0] == x_s2[0])
		else $error("first power differs from the clamped sample");
`endif

endmodule
